/* src/ckde_pkg.sv */
// ----------------------------------------------------------------------------
// ckde_pkg
// Shared types and constants for the circular KDE accumulator.
// ----------------------------------------------------------------------------
package ckde_pkg;

    // Field widths of the item and result channels
    localparam int OP_W    = 2;
    localparam int ANGLE_W = 9;
    localparam int CIDX_W  = 6;
    localparam int COEFF_W = 16;
    localparam int BIDX_W  = 9;
    localparam int ACC_W   = 32;
    localparam int KLEN_W  = 7;

    // Default sizes
    localparam int DEF_KDE_SIZE   = 360;
    localparam int DEF_KERNEL_MAX = 64;

    localparam logic [KLEN_W-1:0] KLEN_RESET = 7'd31;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 2'd0,
        OP_LOAD = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // Control from the sequencer to the density store
    typedef struct packed {
        logic rd_en;
        logic add_en;
    } dens_ctl_t;

    // Status from the density store
    typedef struct packed {
        logic busy;   // clearing pass running
        logic clip;   // current add saturated
    } dens_sts_t;

endpackage

/* src/ckde_density.sv */
// ----------------------------------------------------------------------------
// ckde_density
// Density store: one registered read port, one write port that performs the
// saturating add of a read-modify-write, and a clearing pass after reset.
// ----------------------------------------------------------------------------
module ckde_density #(
    parameter int KDE_SIZE = ckde_pkg::DEF_KDE_SIZE,
    parameter int BIN_W    = $clog2(KDE_SIZE)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ckde_pkg::dens_ctl_t         ctl,
    input  logic [BIN_W-1:0]            rd_addr,
    input  logic [BIN_W-1:0]            add_addr,
    input  logic [ckde_pkg::COEFF_W-1:0] add_val,
    output logic [ckde_pkg::ACC_W-1:0]  rd_data,
    output ckde_pkg::dens_sts_t         sts
);
    import ckde_pkg::*;

    logic [ACC_W-1:0] mem [KDE_SIZE];
    logic [ACC_W-1:0] rd_data_reg;
    logic             clr_busy_reg, clr_busy_next;
    logic [BIN_W-1:0] clr_addr_reg, clr_addr_next;
    logic [ACC_W:0]   sum;
    logic             clip;
    logic [ACC_W-1:0] wdata;

    // Saturating add on the word read in the previous cycle
    assign sum   = {1'b0, rd_data_reg} + (ACC_W+1)'(add_val);
    assign clip  = sum[ACC_W];
    assign wdata = clip ? {ACC_W{1'b1}} : sum[ACC_W-1:0];

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            if (clr_addr_reg == BIN_W'(KDE_SIZE - 1)) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (ctl.add_en) begin
            mem[add_addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign sts.busy = clr_busy_reg;
    assign sts.clip = ctl.add_en & clip;

endmodule

/* src/circular_kde_accumulator_core.sv */
// ----------------------------------------------------------------------------
// circular_kde_accumulator_core
// Circular kernel density accumulator: spreads a stored kernel over a ring of
// density bins around an angle, loads kernel coefficients, reads bins.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  item     | s_valid s_ready s_operation s_angle     | in
//           | s_coeff_index s_coeff_value s_bin_index |
//           | s_last_of_batch                         |
//  result   | m_valid m_ready m_bin_value             | out
//           | m_batch_done m_saturated                |
//  config   | cfg_valid cfg_ready cfg_data            | in
//
// One item is worked on at a time. Load and unused items go straight to
// S_RESULT, a read through S_READ. An add folds the centre in A steps (0 or 1
// when the angle is below KDE_SIZE), spreads over L bins and drains, L =
// active kernel length (one bin read-modify-write per cycle through the single
// density port). After reset a clearing pass zeroes all KDE_SIZE bins; no item
// is taken during it. A waiting result sits in the output register while the
// next item is accepted; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module circular_kde_accumulator_core #(
    parameter int KDE_SIZE   = ckde_pkg::DEF_KDE_SIZE,
    parameter int KERNEL_MAX = ckde_pkg::DEF_KERNEL_MAX
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ckde_pkg::KLEN_W-1:0]   cfg_data,
    // item
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ckde_pkg::OP_W-1:0]     s_operation,
    input  logic [ckde_pkg::ANGLE_W-1:0]  s_angle,
    input  logic [ckde_pkg::CIDX_W-1:0]   s_coeff_index,
    input  logic [ckde_pkg::COEFF_W-1:0]  s_coeff_value,
    input  logic [ckde_pkg::BIDX_W-1:0]   s_bin_index,
    input  logic                          s_last_of_batch,
    // result
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ckde_pkg::ACC_W-1:0]    m_bin_value,
    output logic                          m_batch_done,
    output logic                          m_saturated
);
    import ckde_pkg::*;

    localparam int BIN_W  = $clog2(KDE_SIZE);
    localparam int KIDX_W = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX) : 1;
    localparam int LEN_W  = $clog2(KERNEL_MAX + 1);
    localparam int CMP_W  = (LEN_W > KLEN_W) ? LEN_W : KLEN_W;
    localparam int POS_W  = ((BIN_W > ANGLE_W) ? BIN_W : ANGLE_W) + 2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ALIGN  = 6'b000010,
        S_SPREAD = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_READ   = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [KLEN_W-1:0]       klen_reg, klen_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic [BIN_W-1:0]        bin_reg, bin_next;
    logic [KIDX_W-1:0]       idx_reg, idx_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic                    rd_ok_reg, rd_ok_next;
    logic                    sat_reg, sat_next;
    logic [ACC_W-1:0]        res_value_reg, res_value_next;
    logic                    res_done_reg, res_done_next;
    logic                    add_pend_reg, add_pend_next;
    logic [BIN_W-1:0]        add_addr_reg, add_addr_next;

    logic                    m_valid_reg, m_valid_next;
    logic [ACC_W-1:0]        m_value_reg, m_value_next;
    logic                    m_done_reg, m_done_next;
    logic                    m_sat_reg, m_sat_next;

    logic [COEFF_W-1:0]      kern_mem [KERNEL_MAX];
    logic [COEFF_W-1:0]      kern_q_reg;

    dens_ctl_t               dctl;
    dens_sts_t               dsts;
    logic [BIN_W-1:0]        rd_addr;
    logic [ACC_W-1:0]        rd_data;

    logic                    s_accept;
    op_t                     op;
    logic                    bidx_ok;
    logic                    cidx_ok;
    logic [LEN_W-1:0]        len_act;
    logic                    out_free;
    logic                    pos_neg;
    logic                    pos_high;
    logic signed [POS_W-1:0] pos_delta;

    assign cfg_ready = 1'b1;
    assign s_ready   = state_reg[0] & ~dsts.busy;   // S_IDLE bit
    assign s_accept  = s_valid & s_ready;
    assign op        = op_t'(s_operation);
    assign bidx_ok   = 32'(s_bin_index) < KDE_SIZE;
    assign cidx_ok   = 32'(s_coeff_index) < KERNEL_MAX;
    assign out_free  = ~m_valid_reg | m_ready;

    // Active kernel length, limited to the table size
    assign len_act = (CMP_W'(klen_reg) > CMP_W'(KERNEL_MAX)) ? LEN_W'(KERNEL_MAX)
                                                               : LEN_W'(klen_reg);

    // Shared alignment adder: fold angle - centre into 0 .. KDE_SIZE-1
    assign pos_neg   = pos_reg < 0;
    assign pos_high  = pos_reg >= $signed(POS_W'(KDE_SIZE));
    assign pos_delta = pos_neg ? $signed(POS_W'(KDE_SIZE)) : -$signed(POS_W'(KDE_SIZE));

    always_comb begin
        state_next     = state_reg;
        klen_next      = (cfg_valid && cfg_ready) ? cfg_data : klen_reg;
        pos_next       = pos_reg;
        bin_next       = bin_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        rd_ok_next     = rd_ok_reg;
        sat_next       = sat_reg | dsts.clip;
        res_value_next = res_value_reg;
        res_done_next  = res_done_reg;
        add_pend_next  = 1'b0;
        add_addr_next  = bin_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_value_next   = m_value_reg;
        m_done_next    = m_done_reg;
        m_sat_next     = m_sat_reg;
        dctl.rd_en     = 1'b0;
        dctl.add_en    = add_pend_reg;
        rd_addr        = bin_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    res_value_next = '0;
                    res_done_next  = 1'b0;
                    sat_next       = 1'b0;
                    rd_ok_next     = bidx_ok;
                    len_next       = len_act;
                    pos_next       = $signed(POS_W'(s_angle)) -
                                     $signed(POS_W'(len_act >> 1));
                    case (op)
                        OP_ADD: begin
                            res_done_next = s_last_of_batch;
                            state_next    = (len_act == '0) ? S_RESULT : S_ALIGN;
                        end
                        OP_READ: begin
                            dctl.rd_en = bidx_ok;
                            rd_addr    = BIN_W'(s_bin_index);
                            state_next = S_READ;
                        end
                        default: begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_ALIGN: begin
                if (pos_neg || pos_high) begin
                    pos_next = pos_reg + pos_delta;
                end else begin
                    bin_next   = BIN_W'(pos_reg);
                    idx_next   = '0;
                    state_next = S_SPREAD;
                end
            end
            S_SPREAD: begin
                // read bin and coefficient; the add lands next cycle
                dctl.rd_en    = 1'b1;
                add_pend_next = 1'b1;
                add_addr_next = bin_reg;
                bin_next      = (bin_reg == BIN_W'(KDE_SIZE - 1)) ? '0 : bin_reg + 1'b1;
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == KIDX_W'(len_reg - 1'b1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_RESULT;
            end
            S_READ: begin
                res_value_next = rd_ok_reg ? rd_data : '0;
                state_next     = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_value_reg;
                    m_done_next  = res_done_reg;
                    m_sat_next   = sat_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            klen_reg     <= KLEN_RESET;
            add_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            klen_reg     <= klen_next;
            add_pend_reg <= add_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        bin_reg       <= bin_next;
        idx_reg       <= idx_next;
        len_reg       <= len_next;
        rd_ok_reg     <= rd_ok_next;
        sat_reg       <= sat_next;
        res_value_reg <= res_value_next;
        res_done_reg  <= res_done_next;
        add_addr_reg  <= add_addr_next;
        m_value_reg   <= m_value_next;
        m_done_reg    <= m_done_next;
        m_sat_reg     <= m_sat_next;
    end

    // Kernel table: written by load items, read one entry per spread cycle
    always_ff @(posedge aclk) begin
        if (s_accept && op == OP_LOAD && cidx_ok) begin
            kern_mem[KIDX_W'(s_coeff_index)] <= s_coeff_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_SPREAD) begin
            kern_q_reg <= kern_mem[idx_reg];
        end
    end

    ckde_density #(
        .KDE_SIZE (KDE_SIZE),
        .BIN_W    (BIN_W)
    ) u_density (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (dctl),
        .rd_addr  (rd_addr),
        .add_addr (add_addr_reg),
        .add_val  (kern_q_reg),
        .rd_data  (rd_data),
        .sts      (dsts)
    );

    assign m_valid      = m_valid_reg;
    assign m_bin_value  = m_value_reg;
    assign m_batch_done = m_done_reg;
    assign m_saturated  = m_sat_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        dsts.busy |-> !s_ready)
        else $error("item taken during clearing pass");

    a_add_only_spreading: assert property (@(posedge aclk) disable iff (!aresetn)
        dctl.add_en |-> (state_reg == S_SPREAD || state_reg == S_DRAIN))
        else $error("density add outside spread");

    a_bin_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SPREAD) |-> (32'(bin_reg) < KDE_SIZE))
        else $error("spread bin out of range");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after an item");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular KDE accumulator core. A short table
// of directed items and register writes comes first, then the whole kernel is
// loaded and random phases run at several kernel lengths. One phase runs with
// no idling on either side. Every result is checked field by field against a
// typed expectation or an in-bench density and kernel model.
// ----------------------------------------------------------------------------
module tb_top;
    import ckde_pkg::*;

    localparam int KDE_SIZE    = DEF_KDE_SIZE;
    localparam int KERNEL_MAX  = DEF_KERNEL_MAX;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;    // long result-side hold-off
    localparam int TAIL_CYCLES = 100;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES  = 8;

    typedef struct packed {
        op_t                op;
        logic [ANGLE_W-1:0] angle;
        logic [CIDX_W-1:0]  cidx;
        logic [COEFF_W-1:0] cval;
        logic [BIDX_W-1:0]  bidx;
        logic               last;
    } kde_item_t;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             done;
        logic             sat;
    } kde_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // One directed step: either a kernel_length write or an item. Where
    // has_ref is set the typed result is the expectation, otherwise the model.
    typedef struct packed {
        row_kind_t          kind;
        logic [KLEN_W-1:0]  klen;
        op_t                op;
        logic [ANGLE_W-1:0] angle;
        logic [CIDX_W-1:0]  cidx;
        logic [COEFF_W-1:0] cval;
        logic [BIDX_W-1:0]  bidx;
        logic               last;
        logic               has_ref;
        logic [ACC_W-1:0]   value;
        logic               done;
        logic               sat;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // kind    klen   op       angle   cidx   coeff     bin     last  ref   value
        '{ROW_CFG,  7'd1, OP_NONE, 9'd0,   6'd0,  16'h0000, 9'd0,   1'b0, 1'b0, 32'd0,
          1'b0, 1'b0},
        // store is clear after reset, top bin included
        '{ROW_ITEM, 7'd0, OP_READ, 9'd0,   6'd0,  16'h0000, 9'd0,   1'b0, 1'b1, 32'd0,
          1'b0, 1'b0},
        '{ROW_ITEM, 7'd0, OP_READ, 9'd0,   6'd0,  16'h0000, 9'd359, 1'b0, 1'b1, 32'd0,
          1'b0, 1'b0},
        // bin index past the ring reads zero
        '{ROW_ITEM, 7'd0, OP_READ, 9'd0,   6'd0,  16'h0000, 9'd511, 1'b0, 1'b1, 32'd0,
          1'b0, 1'b0},
        // unused op code with every field at its top
        '{ROW_ITEM, 7'd0, OP_NONE, 9'd511, 6'd63, 16'hFFFF, 9'd511, 1'b1, 1'b1, 32'd0,
          1'b0, 1'b0},
        // coefficient of exactly 1.0
        '{ROW_ITEM, 7'd0, OP_LOAD, 9'd0,   6'd0,  16'h8000, 9'd0,   1'b0, 1'b1, 32'd0,
          1'b0, 1'b0},
        '{ROW_ITEM, 7'd0, OP_ADD,  9'd0,   6'd0,  16'h0000, 9'd0,   1'b1, 1'b1, 32'd0,
          1'b1, 1'b0},
        // 360 folds back onto bin 0
        '{ROW_ITEM, 7'd0, OP_ADD,  9'd360, 6'd0,  16'h0000, 9'd0,   1'b0, 1'b1, 32'd0,
          1'b0, 1'b0},
        '{ROW_ITEM, 7'd0, OP_READ, 9'd0,   6'd0,  16'h0000, 9'd0,   1'b0, 1'b1, 32'd65536,
          1'b0, 1'b0},
        // coefficient above 1.0 is kept as given
        '{ROW_ITEM, 7'd0, OP_LOAD, 9'd0,   6'd63, 16'hFFFF, 9'd0,   1'b0, 1'b1, 32'd0,
          1'b0, 1'b0},
        '{ROW_ITEM, 7'd0, OP_LOAD, 9'd0,   6'd1,  16'h4000, 9'd0,   1'b0, 1'b1, 32'd0,
          1'b0, 1'b0},
        '{ROW_ITEM, 7'd0, OP_LOAD, 9'd0,   6'd2,  16'hFFFF, 9'd0,   1'b0, 1'b1, 32'd0,
          1'b0, 1'b0},
        // angle far past the ring: 511 folds to 151
        '{ROW_ITEM, 7'd0, OP_ADD,  9'd511, 6'd0,  16'h0000, 9'd0,   1'b0, 1'b0, 32'd0,
          1'b0, 1'b0},
        '{ROW_ITEM, 7'd0, OP_READ, 9'd0,   6'd0,  16'h0000, 9'd151, 1'b0, 1'b0, 32'd0,
          1'b0, 1'b0},
        // three taps centred on the last bin wrap into bin 0
        '{ROW_CFG,  7'd3, OP_NONE, 9'd0,   6'd0,  16'h0000, 9'd0,   1'b0, 1'b0, 32'd0,
          1'b0, 1'b0},
        '{ROW_ITEM, 7'd0, OP_ADD,  9'd359, 6'd0,  16'h0000, 9'd0,   1'b1, 1'b0, 32'd0,
          1'b0, 1'b0},
        '{ROW_ITEM, 7'd0, OP_READ, 9'd0,   6'd0,  16'h0000, 9'd0,   1'b0, 1'b0, 32'd0,
          1'b0, 1'b0},
        '{ROW_ITEM, 7'd0, OP_READ, 9'd0,   6'd0,  16'h0000, 9'd358, 1'b0, 1'b0, 32'd0,
          1'b0, 1'b0},
        // zero-length kernel: add touches nothing
        '{ROW_CFG,  7'd0, OP_NONE, 9'd0,   6'd0,  16'h0000, 9'd0,   1'b0, 1'b0, 32'd0,
          1'b0, 1'b0},
        '{ROW_ITEM, 7'd0, OP_ADD,  9'd100, 6'd0,  16'h0000, 9'd0,   1'b1, 1'b1, 32'd0,
          1'b1, 1'b0},
        '{ROW_ITEM, 7'd0, OP_READ, 9'd0,   6'd0,  16'h0000, 9'd100, 1'b0, 1'b1, 32'd0,
          1'b0, 1'b0},
        // even length: centre sits one bin early, wraps below bin 0
        '{ROW_CFG,  7'd2, OP_NONE, 9'd0,   6'd0,  16'h0000, 9'd0,   1'b0, 1'b0, 32'd0,
          1'b0, 1'b0},
        '{ROW_ITEM, 7'd0, OP_ADD,  9'd0,   6'd0,  16'h0000, 9'd0,   1'b0, 1'b0, 32'd0,
          1'b0, 1'b0},
        '{ROW_ITEM, 7'd0, OP_READ, 9'd0,   6'd0,  16'h0000, 9'd359, 1'b0, 1'b0, 32'd0,
          1'b0, 1'b0}
    };

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [KLEN_W-1:0]   cfg_data  = '0;

    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation     = '0;
    logic [ANGLE_W-1:0]  s_angle         = '0;
    logic [CIDX_W-1:0]   s_coeff_index   = '0;
    logic [COEFF_W-1:0]  s_coeff_value   = '0;
    logic [BIDX_W-1:0]   s_bin_index     = '0;
    logic                s_last_of_batch = 1'b0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [ACC_W-1:0]    m_bin_value;
    logic                m_batch_done;
    logic                m_saturated;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    circular_kde_accumulator_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_angle         (s_angle),
        .s_coeff_index   (s_coeff_index),
        .s_coeff_value   (s_coeff_value),
        .s_bin_index     (s_bin_index),
        .s_last_of_batch (s_last_of_batch),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_bin_value     (m_bin_value),
        .m_batch_done    (m_batch_done),
        .m_saturated     (m_saturated)
    );

    // ------------------------------------------------------------------------
    // Model state and bookkeeping
    // ------------------------------------------------------------------------
    logic [ACC_W-1:0]   density_model [KDE_SIZE];
    logic [COEFF_W-1:0] kernel_model  [KERNEL_MAX];
    logic [KLEN_W-1:0]  klen_model = KLEN_RESET;

    kde_result_t pending_results [$];

    bit          idling_on      = 1'b1;  // random gaps on both sides
    int unsigned hold_requests  = 0;     // bumped by stimulus, served by sink
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned items_by_op [4] = '{0, 0, 0, 0};
    int unsigned results_seen   = 0;
    int unsigned clipped_seen   = 0;
    int unsigned klen_writes    = 0;

    task automatic report_mismatch(input string what, input logic [ACC_W-1:0] got,
                                   input logic [ACC_W-1:0] want);
        $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
        mismatches++;
    endtask

    // Predicts one item's result and updates the density/kernel model.
    // Kernel tap i lands on bin (angle - len/2 + i) mod KDE_SIZE, clip at max.
    function automatic kde_result_t predict_kde_result(input kde_item_t it);
        kde_result_t    res;
        int             len;
        int             pos;
        logic [ACC_W:0] sum;
        res = '0;
        case (it.op)
            OP_ADD: begin
                len = (int'(klen_model) > KERNEL_MAX) ? KERNEL_MAX : int'(klen_model);
                pos = (int'(it.angle) % KDE_SIZE + KDE_SIZE - (len / 2) % KDE_SIZE)
                      % KDE_SIZE;
                for (int i = 0; i < len; i++) begin
                    sum = {1'b0, density_model[pos]} + (ACC_W + 1)'(kernel_model[i]);
                    if (sum[ACC_W]) begin
                        density_model[pos] = '1;
                        res.sat = 1'b1;
                    end else begin
                        density_model[pos] = sum[ACC_W-1:0];
                    end
                    pos = (pos + 1 == KDE_SIZE) ? 0 : pos + 1;
                end
                res.done = it.last;
            end
            OP_LOAD: begin
                kernel_model[it.cidx] = it.cval;
            end
            OP_READ: begin
                if (int'(it.bidx) < KDE_SIZE)
                    res.value = density_model[it.bidx];
            end
            default: ;
        endcase
        return res;
    endfunction

    // Random item; every field is filled whatever the op, so unused fields
    // carry junk too. Angles and bins past the ring show up now and then.
    function automatic kde_item_t random_item();
        kde_item_t   it;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 55)
            it.op = OP_ADD;
        else if (sel < 75)
            it.op = OP_LOAD;
        else if (sel < 95)
            it.op = OP_READ;
        else
            it.op = OP_NONE;
        it.angle = ($urandom_range(9) == 0) ? ANGLE_W'($urandom_range(511, 360))
                                            : ANGLE_W'($urandom_range(359));
        it.cidx  = CIDX_W'($urandom_range(63));
        case ($urandom_range(7))
            0:       it.cval = 16'h0000;
            1:       it.cval = 16'h8000;
            2:       it.cval = 16'hFFFF;
            default: it.cval = COEFF_W'($urandom_range(65535));
        endcase
        it.bidx  = ($urandom_range(9) == 0) ? BIDX_W'($urandom_range(511, 360))
                                            : BIDX_W'($urandom_range(359));
        it.last  = ($urandom_range(3) == 0);
        return it;
    endfunction

    // Offers one item, holds it until taken, then queues its expectation.
    task automatic send_item(input kde_item_t it, input logic has_ref,
                             input kde_result_t ref_res);
        kde_result_t predicted;
        while (idling_on && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= it.op;
        s_angle         <= it.angle;
        s_coeff_index   <= it.cidx;
        s_coeff_value   <= it.cval;
        s_bin_index     <= it.bidx;
        s_last_of_batch <= it.last;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_kde_result(it);
        pending_results.push_back(has_ref ? ref_res : predicted);
        items_by_op[it.op]++;
    endtask

    // Stops offering and waits until every queued result has come back.
    // Always waits on the clock first, so s_valid never flips twice in a step.
    task automatic drain_all();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_klen(input logic [KLEN_W-1:0] v);
        drain_all();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        klen_model = v;
        klen_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready with random gaps, plus long hold-offs on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned holds_served;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                // block fills up behind this and has to drop s_ready
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_served++;
            end
            m_ready <= !(idling_on && $urandom_range(99) < 15);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        kde_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_bin_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_bin_value !== want.value)
                    report_mismatch("bin_value", m_bin_value, want.value);
                if (m_batch_done !== want.done)
                    report_mismatch("batch_done", ACC_W'(m_batch_done), ACC_W'(want.done));
                if (m_saturated !== want.sat)
                    report_mismatch("saturated", ACC_W'(m_saturated), ACC_W'(want.sat));
            end
            results_seen++;
            if (m_saturated === 1'b1)
                clipped_seen++;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        kde_item_t   it;
        kde_result_t no_ref;
        dir_row_t    row;
        int unsigned phase_klen [NUM_PHASES];

        no_ref = '0;
        foreach (density_model[b])
            density_model[b] = '0;
        foreach (kernel_model[k])
            kernel_model[k] = '0;
        // extremes first; above-max length folds to 64; last one random
        phase_klen = '{127, 64, 1, 63, 0, 31, 2, 0};
        phase_klen[NUM_PHASES-1] = $urandom_range(127);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table; the first item also waits out the clearing pass,
        // since s_ready stays low during it
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TABLE[r];
            if (row.kind == ROW_CFG) begin
                write_klen(row.klen);
            end else begin
                it = '{row.op, row.angle, row.cidx, row.cval, row.bidx, row.last};
                send_item(it, row.has_ref, '{row.value, row.done, row.sat});
            end
        end

        // Load the whole kernel so no add ever reads an unwritten tap
        for (int k = 0; k < KERNEL_MAX; k++) begin
            it      = random_item();
            it.op   = OP_LOAD;
            it.cidx = CIDX_W'(k);
            send_item(it, 1'b1, no_ref);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_klen(KLEN_W'(phase_klen[p]));
            // one whole phase without gaps on either side
            if (p == 3)
                idling_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 20)
                    hold_requests++;
                if (p == 2 && n == 60)
                    drain_all();   // sender pause until the pipe is empty
                send_item(random_item(), 1'b0, no_ref);
            end
            idling_on = 1'b1;
        end

        drain_all();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("coverage: %0d items (%0d add, %0d load, %0d read, %0d unused op)",
                 items_by_op[0] + items_by_op[1] + items_by_op[2] + items_by_op[3],
                 items_by_op[0], items_by_op[1], items_by_op[2], items_by_op[3]);
        $display("coverage: %0d results, %0d clipped, %0d kernel_length writes, %0d cycles",
                 results_seen, clipped_seen, klen_writes, cycle_count);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
